[src/sbmq_pkg.sv]
// ----------------------------------------------------------------------------
// sbmq_pkg
// Types and constants for the shared-buffer multi-queue manager.
// ----------------------------------------------------------------------------
package sbmq_pkg;

	localparam int SLOTS_DEF  = 16;
	localparam int QUEUES_DEF = 4;

	localparam int OP_W   = 2;
	localparam int QID_W  = 2;
	localparam int DATA_W = 32;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [QID_W-1:0]         queue_id;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [ST_W-1:0]          status;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic fetch;
	} ctl_sts_t;

endpackage

[src/sbmq_ctrl.sv]
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer: capture request, execute, optional second read for dequeue/peek.
// ----------------------------------------------------------------------------
module sbmq_ctrl import sbmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.fetch ? S_FETCH : S_IDLE;
			end
			S_FETCH: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[src/sbmq_datapath.sv]
// ----------------------------------------------------------------------------
// sbmq_datapath
// Head/tail/link/data stores, free list and fill count, result register.
// ----------------------------------------------------------------------------
module sbmq_datapath import sbmq_pkg::*; #(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int QUEUES = QUEUES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output logic     done,
	output res_t     res
);

	localparam int AW = $clog2(SLOTS);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int XW = (QW > QID_W) ? QW : QID_W;

	typedef struct packed {
		logic          vld;
		logic [AW-1:0] idx;
	} lnk_t;

	// stores
	logic [AW-1:0]           head_mem [QUEUES];
	logic [AW-1:0]           tail_mem [QUEUES];
	lnk_t                    lnk_mem  [SLOTS];
	logic signed [DATA_W-1:0] data_mem [SLOTS];

	// control state
	logic [(1<<QW)-1:0] head_vld_q;
	logic               free_vld_q;
	logic [AW-1:0]      free_idx_q;
	logic [AW:0]        fill_q;
	logic               done_q;

	// payload registers
	req_t                     req_q;
	res_t                     res_q;
	logic [AW-1:0]            head_rd_q;
	logic [AW-1:0]            tail_rd_q;
	lnk_t                     lnk_rd_q;
	logic [AW-1:0]            lnk_ra_q;
	logic                     lnk_fresh_q;
	logic signed [DATA_W-1:0] data_rd_q;

	logic [XW-1:0] qx_in;
	logic [XW-1:0] qx;
	logic [QW-1:0] qi_in;
	logic [QW-1:0] qi;
	logic          q_ok;
	logic          hv;
	logic          enq_go;
	logic          fetch;
	logic [ST_W-1:0] st;
	lnk_t          lnk_eff;

	logic          lnk_re;
	logic [AW-1:0] lnk_ra;
	logic          lnk_we;
	logic [AW-1:0] lnk_wa;
	lnk_t          lnk_wd;
	logic          head_we;
	logic [AW-1:0] head_wd;
	logic          deq_go;

	assign qx_in = XW'(req.queue_id);
	assign qi_in = qx_in[QW-1:0];
	assign qx    = XW'(req_q.queue_id);
	assign qi    = qx[QW-1:0];
	assign q_ok  = (32'(req_q.queue_id) < 32'(QUEUES));
	assign hv    = head_vld_q[qi];

	// slots at or above the fill count still hold their reset link
	always_comb begin
		if (lnk_fresh_q) begin
			lnk_eff.vld = (lnk_ra_q != AW'(SLOTS - 1));
			lnk_eff.idx = lnk_ra_q + AW'(1);
		end else begin
			lnk_eff = lnk_rd_q;
		end
	end

	always_comb begin
		enq_go = 1'b0;
		fetch  = 1'b0;
		st     = ST_OK;
		unique case (req_q.op) inside
			OP_ENQ: begin
				if (!q_ok) begin
					st = ST_EMPTY;
				end else if (!free_vld_q) begin
					st = ST_FULL;
				end else begin
					enq_go = 1'b1;
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (!q_ok || !hv) begin
					st = ST_EMPTY;
				end else begin
					fetch = 1'b1;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign sts.fetch = fetch;
	assign deq_go    = cmd.finish && (req_q.op == OP_DEQ);

	always_comb begin
		lnk_re = cmd.capture || (cmd.exec && fetch);
		lnk_ra = cmd.capture ? free_idx_q : head_rd_q;
		lnk_we = 1'b0;
		lnk_wa = tail_rd_q;
		lnk_wd = '{vld: 1'b1, idx: free_idx_q};
		if (cmd.exec && enq_go && hv) begin
			lnk_we = 1'b1;
		end else if (deq_go) begin
			lnk_we = 1'b1;
			lnk_wa = head_rd_q;
			lnk_wd = '{vld: free_vld_q, idx: free_idx_q};
		end
		head_we = (cmd.exec && enq_go && !hv) || deq_go;
		head_wd = deq_go ? lnk_eff.idx : free_idx_q;
	end

	// link store
	always_ff @(posedge clk) begin
		if (lnk_re) begin
			lnk_rd_q    <= lnk_mem[lnk_ra];
			lnk_ra_q    <= lnk_ra;
			lnk_fresh_q <= ({1'b0, lnk_ra} >= fill_q);
		end
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
	end

	// data store
	always_ff @(posedge clk) begin
		if (cmd.exec && fetch) begin
			data_rd_q <= data_mem[head_rd_q];
		end
		if (cmd.exec && enq_go) begin
			data_mem[free_idx_q] <= req_q.data_in;
		end
	end

	// head and tail stores
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req;
			head_rd_q <= head_mem[qi_in];
			tail_rd_q <= tail_mem[qi_in];
		end
		if (head_we) begin
			head_mem[qi] <= head_wd;
		end
		if (cmd.exec && enq_go) begin
			tail_mem[qi] <= free_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			free_vld_q <= 1'b1;
			free_idx_q <= '0;
			fill_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (cmd.exec && !fetch) || cmd.finish;
			if (cmd.exec && enq_go) begin
				head_vld_q[qi] <= 1'b1;
				free_vld_q     <= lnk_eff.vld;
				free_idx_q     <= lnk_eff.idx;
				if ({1'b0, free_idx_q} == fill_q) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
			end else if (deq_go) begin
				// the tail is the only element whose link is not kept
				head_vld_q[qi] <= (head_rd_q != tail_rd_q);
				free_vld_q     <= 1'b1;
				free_idx_q     <= head_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !fetch) begin
			res_q.data_out <= '0;
			res_q.status   <= st;
		end else if (cmd.finish) begin
			res_q.data_out <= data_rd_q;
			res_q.status   <= ST_OK;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[src/shared_buffer_multi_queue.sv]
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Several FIFO queues in one linked slot store with a shared free list.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   request  | start, busy           | req  (op, queue_id, data_in)
//   result   | done (one-cycle pulse)| res  (data_out, status)
//
// A request is taken when start is high and busy is low. Enqueue, failed ops
// and no-ops run capture and execute; dequeue/peek with a word add a finish
// step, set by the dependent read of the head store, then the link/data
// stores. The result is registered and pulses done the cycle after the last
// step, while the block may already take a new request; the receiver cannot
// stall. After reset all queues are empty and the block is ready at once.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue import sbmq_pkg::*; #(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int QUEUES = QUEUES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	sbmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sbmq_datapath #(
		.SLOTS  (SLOTS),
		.QUEUES (QUEUES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.res    (res)
	);

endmodule

[bench/sbmq_score_pkg.sv]
// ----------------------------------------------------------------------------
// sbmq_score_pkg
// Scoreboard for the shared-buffer multi-queue manager: tracks the linked
// slot store, head/tail pointers and free list, and checks each result in
// order against the expected one.
// ----------------------------------------------------------------------------
package sbmq_score_pkg;
	import sbmq_pkg::*;

	localparam int NO_SLOT = -1;

	class mq_scoreboard;
		int head_slot[QUEUES_DEF];
		int tail_slot[QUEUES_DEF];
		int next_slot[SLOTS_DEF];
		logic signed [DATA_W-1:0] slot_word[SLOTS_DEF];
		int free_top;

		res_t pending_results[$];
		int n_requests;
		int n_results;
		int n_mismatch;
		int n_ok;
		int n_full;
		int n_empty;

		function new();
			for (int q = 0; q < QUEUES_DEF; q++) begin
				head_slot[q] = NO_SLOT;
				tail_slot[q] = NO_SLOT;
			end
			for (int s = 0; s < SLOTS_DEF; s++) begin
				next_slot[s] = (s + 1 < SLOTS_DEF) ? s + 1 : NO_SLOT;
				slot_word[s] = '0;
			end
			free_top = 0;
			n_requests = 0;
			n_results = 0;
			n_mismatch = 0;
			n_ok = 0;
			n_full = 0;
			n_empty = 0;
		endfunction

		// apply one accepted request to the tracked state, queue its result
		function void take_request(req_t r);
			res_t exp;
			int q;
			int s;
			q = int'(r.queue_id);
			exp.data_out = '0;
			exp.status = ST_OK;
			case (r.op) inside
				OP_ENQ: begin
					if (q >= QUEUES_DEF) begin
						exp.status = ST_EMPTY;
					end else if (free_top == NO_SLOT) begin
						exp.status = ST_FULL;
					end else begin
						s = free_top;
						free_top = next_slot[s];
						if (head_slot[q] == NO_SLOT)
							head_slot[q] = s;
						else
							next_slot[tail_slot[q]] = s;
						next_slot[s] = NO_SLOT;
						tail_slot[q] = s;
						slot_word[s] = r.data_in;
					end
				end
				OP_DEQ, OP_PEEK: begin
					if (q >= QUEUES_DEF || head_slot[q] == NO_SLOT) begin
						exp.status = ST_EMPTY;
					end else begin
						s = head_slot[q];
						exp.data_out = slot_word[s];
						if (r.op == OP_DEQ) begin
							head_slot[q] = next_slot[s];
							next_slot[s] = free_top;
							free_top = s;
						end
					end
				end
				default: ;
			endcase
			case (exp.status)
				ST_OK: n_ok++;
				ST_FULL: n_full++;
				default: n_empty++;
			endcase
			n_requests++;
			pending_results.push_back(exp);
		endfunction

		function void check_result(res_t got);
			res_t exp;
			n_results++;
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: data_out %0d status %0d",
						got.data_out, got.status);
				return;
			end
			exp = pending_results.pop_front();
			if (got.data_out !== exp.data_out || got.status !== exp.status) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display({"mismatch on result %0d: exp data_out %0d status %0d, ",
						"got data_out %0d status %0d"},
						n_results, exp.data_out, exp.status, got.data_out, got.status);
			end
		endfunction
	endclass

endpackage

[bench/tb_shared_buffer_multi_queue.sv]
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue
// Drives enqueue/dequeue/peek/no-op requests into the multi-queue manager,
// first a directed sequence through empty, extreme words and a full store,
// then biased random traffic that fills and drains the shared slots, with
// phases of sender idling. Every done pulse is checked against a tracked
// copy of the queues.
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue;
	import sbmq_pkg::*;
	import sbmq_score_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 780;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t res;

	mq_scoreboard sb;
	int idle_pct;
	int quiet_cycles;

	shared_buffer_multi_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(res);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("timeout: no request or result for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	function automatic req_t make_req(logic [OP_W-1:0] op, logic [QID_W-1:0] qid,
			logic signed [DATA_W-1:0] word);
		req_t r;
		r.op = op;
		r.queue_id = qid;
		r.data_in = word;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic issue(input req_t r);
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		sb.take_request(r);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	initial begin
		int mode;
		int focus;
		int pick;
		logic [OP_W-1:0] op;
		logic [QID_W-1:0] qid;

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queues, extreme words, no-ops, then fill the store to full
		issue(make_req(OP_PEEK, 2'd0, 32'h1234_5678));
		issue(make_req(OP_DEQ, 2'd2, '0));
		issue(make_req(OP_ENQ, 2'd0, 32'h8000_0000));
		issue(make_req(OP_ENQ, 2'd3, 32'h7fff_ffff));
		issue(make_req(OP_ENQ, 2'd1, 32'h0000_0000));
		issue(make_req(OP_ENQ, 2'd2, 32'hffff_ffff));
		issue(make_req(OP_PEEK, 2'd3, '0));
		issue(make_req(OP_DEQ, 2'd0, '0));
		issue(make_req(OP_DEQ, 2'd0, '0));
		issue(make_req(OP_NOP, 2'd3, 32'hffff_ffff));
		issue(make_req(OP_NOP, 2'd0, '0));
		for (int i = 0; i < 13; i++)
			issue(make_req(OP_ENQ, 2'd1, pick_word()));
		issue(make_req(OP_ENQ, 2'd3, 32'h5a5a_a5a5));

		mode = 0;
		focus = -1;
		for (int i = 0; i < N_RANDOM; i++) begin
			case ((i * 4) / N_RANDOM)
				0: idle_pct = 0;
				1: idle_pct = 87;
				2: idle_pct = 0;
				default: idle_pct = 19;
			endcase
			if (i % 40 == 0) begin
				mode = $urandom_range(2);
				focus = ($urandom_range(3) == 0) ? $urandom_range(QUEUES_DEF - 1) : -1;
			end
			pick = $urandom_range(99);
			case (mode)
				0: op = (pick < 70) ? OP_ENQ : (pick < 82) ? OP_DEQ :
					(pick < 95) ? OP_PEEK : OP_NOP;
				1: op = (pick < 15) ? OP_ENQ : (pick < 70) ? OP_DEQ :
					(pick < 95) ? OP_PEEK : OP_NOP;
				default: op = (pick < 40) ? OP_ENQ : (pick < 75) ? OP_DEQ :
					(pick < 93) ? OP_PEEK : OP_NOP;
			endcase
			qid = (focus >= 0) ? QID_W'(focus) : QID_W'($urandom_range(QUEUES_DEF - 1));
			issue(make_req(op, qid, (op == OP_ENQ) ? pick_word() : $urandom));
		end
		start <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("requests %0d, results %0d: ok %0d, full %0d, empty %0d",
			sb.n_requests, sb.n_results, sb.n_ok, sb.n_full, sb.n_empty);
		$display("fill/drain/balanced mixes, sender idling 0/87/19 pct, mismatches %0d",
			sb.n_mismatch);
		if (sb.n_mismatch == 0 && sb.pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[shared_buffer_multi_queue.f]
src/sbmq_pkg.sv
src/sbmq_ctrl.sv
src/sbmq_datapath.sv
src/shared_buffer_multi_queue.sv
bench/sbmq_score_pkg.sv
bench/tb_shared_buffer_multi_queue.sv
